// ===== sv/mvna_pkg.sv =====
// shared types, constants and command codes of the mesh vertex normal accumulator
`default_nettype none

package mvna_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int POS_W        = 24;
    localparam int NRM_W        = 16;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_TRI  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;
    localparam logic [1:0] KIND_NEW  = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_LATCH     = 5'd1;
    localparam logic [4:0] OP_SCALE     = 5'd2;
    localparam logic [4:0] OP_WR_VTX    = 5'd3;
    localparam logic [4:0] OP_RD_POS    = 5'd4;
    localparam logic [4:0] OP_LOAD_L    = 5'd5;
    localparam logic [4:0] OP_LOAD_R    = 5'd6;
    localparam logic [4:0] OP_SHIFT     = 5'd7;
    localparam logic [4:0] OP_NRM_ZERO  = 5'd8;
    localparam logic [4:0] OP_SQ        = 5'd9;
    localparam logic [4:0] OP_ISQ_INIT  = 5'd10;
    localparam logic [4:0] OP_ISQ_STEP  = 5'd11;
    localparam logic [4:0] OP_DIV_INIT  = 5'd12;
    localparam logic [4:0] OP_DIV_STEP  = 5'd13;
    localparam logic [4:0] OP_DIV_END   = 5'd14;
    localparam logic [4:0] OP_NRM_STORE = 5'd15;
    localparam logic [4:0] OP_CROSS     = 5'd16;
    localparam logic [4:0] OP_RD_NRM    = 5'd17;
    localparam logic [4:0] OP_WR_NRM    = 5'd18;
    localparam logic [4:0] OP_RD_VTX    = 5'd19;
    localparam logic [4:0] OP_CLEAR     = 5'd20;
    localparam logic [4:0] OP_RES_ZERO  = 5'd21;
    localparam logic [4:0] OP_RES_ADD   = 5'd22;
    localparam logic [4:0] OP_RES_TRI   = 5'd23;
    localparam logic [4:0] OP_RES_READ  = 5'd24;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [23:0] coord_x;
        logic signed [23:0] coord_y;
        logic signed [23:0] coord_z;
        logic [10:0]        corner_a;
        logic [10:0]        corner_b;
        logic [10:0]        corner_c;
        logic [9:0]         read_index;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       corner_bad;
        logic       read_bad;
        logic       mx_zero;
        logic       mx_big;
        logic       out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/mesh_vertex_normal_accumulator.sv =====
// top level of the mesh vertex normal accumulator
//
//  channel  direction  handshake                 beat
//  in       input      in_valid / in_ready       in_item_t: kind, coords, corners, index
//  out      output     out_valid / out_ready     out_item_t: position, normal, status
//  cfg      input      cfg_valid / cfg_ready     16-bit position scale, Q8.8
//
// one item in flight; a result waits in the output register while the next beat is taken
// triangle: three normalisations, each shifting the vector up, then a 32-step square root
// and three 16-step divisions on one shared unit, then three normal store read-modify-writes
// reset empties the mesh and sets the scale to 1.0; no clearing pass is needed
`default_nettype none

module mesh_vertex_normal_accumulator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mvna_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mvna_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import mvna_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mvna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mvna_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== sv/mvna_dp.sv =====
// datapath: vertex and normal stores, shared multiplier, square root and divider units
`default_nettype none

module mvna_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mvna_pkg::dp_cmd_t   cmd,
    output mvna_pkg::dp_stat_t  stat,
    input  mvna_pkg::in_item_t  in_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mvna_pkg::out_item_t out_data
);
    import mvna_pkg::*;

    localparam logic [2:0] MP_NONE  = 3'd0;
    localparam logic [2:0] MP_SCALE = 3'd1;
    localparam logic [2:0] MP_SQ    = 3'd2;
    localparam logic [2:0] MP_XSET  = 3'd3;
    localparam logic [2:0] MP_XSUB  = 3'd4;

    localparam logic signed [23:0] POS_MAX = 24'sh7fffff;
    localparam logic signed [23:0] POS_MIN = 24'sh800000;

    in_item_t                  item_reg;
    logic [IDX_W-1:0]          vi_reg [3];
    logic [CNT_W-1:0]          count_reg;
    logic [15:0]               scale_reg;

    logic [3*POS_W-1:0]        pos_mem [MAX_VERTICES];
    logic [3*NRM_W-1:0]        nrm_mem [MAX_VERTICES];
    logic [3*POS_W-1:0]        pos_q_reg;
    logic [3*NRM_W-1:0]        nrm_q_reg;

    logic [3*POS_W-1:0]        pp_reg [3];
    logic                      rdp_pend_reg;
    logic [1:0]                rdp_sel_reg;
    logic signed [POS_W-1:0]   pnew_reg [3];

    logic signed [31:0]        d_reg [3];
    logic signed [NRM_W-1:0]   ln_reg [3];
    logic signed [NRM_W-1:0]   rn_reg [3];
    logic signed [NRM_W-1:0]   fn_reg [3];
    logic signed [NRM_W-1:0]   nres_reg [3];

    logic signed [31:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [63:0]        prod_reg;
    logic [2:0]                mop_reg;
    logic [2:0]                msel_reg;

    logic [61:0]               ssum_reg;
    logic [61:0]               iv_reg;
    logic [62:0]               ir_reg;
    logic [62:0]               ibit_reg;
    logic [30:0]               len;

    logic [30:0]               drem_reg;
    logic [15:0]               dlo_reg;
    logic [15:0]               dq_reg;
    logic                      dneg_reg;

    out_item_t                 out_reg;
    logic                      out_valid_reg;

    logic [IDX_W-1:0]          vsel;
    logic signed [31:0]        dsel;
    logic signed [31:0]        scoord;
    logic [30:0]               dmag [3];
    logic [40:0]               smag;
    logic [32:0]               sq;
    logic signed [POS_W-1:0]   srnd;
    logic [63:0]               isum;
    logic                      ige;
    logic [44:0]               dnum;
    logic [31:0]               dtry;
    logic                      dge;
    logic signed [NRM_W-1:0]   nq [3];
    logic signed [NRM_W:0]     nsum [3];
    logic signed [NRM_W-1:0]   mc [3];
    logic                      nz;
    logic                      res_op;

    function automatic logic [30:0] abs32(input logic signed [31:0] v);
        logic signed [31:0] n;
        begin
            n = -v;
            abs32 = v[31] ? n[30:0] : v[30:0];
        end
    endfunction

    function automatic logic signed [POS_W-1:0] pcomp(input logic [3*POS_W-1:0] w,
                                                      input int i);
        begin
            pcomp = w[(2-i)*POS_W +: POS_W];
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign len       = ir_reg[30:0];
    assign vsel      = vi_reg[cmd.sel[1:0]];
    assign res_op    = (cmd.op == OP_RES_ZERO) || (cmd.op == OP_RES_ADD) ||
                       (cmd.op == OP_RES_TRI) || (cmd.op == OP_RES_READ);

    always_comb
    begin
        case (cmd.sel[1:0])
            2'd0:    dsel = d_reg[0];
            2'd1:    dsel = d_reg[1];
            default: dsel = d_reg[2];
        endcase
        case (cmd.sel[1:0])
            2'd0:    scoord = 32'(item_reg.coord_x);
            2'd1:    scoord = 32'(item_reg.coord_y);
            default: scoord = -32'(item_reg.coord_z);
        endcase
    end

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SCALE:
            begin
                mul_a = scoord;
                mul_b = {16'd0, scale_reg};
            end
            OP_SQ:
            begin
                mul_a = dsel;
                mul_b = dsel;
            end
            OP_CROSS:
            begin
                case (cmd.sel)
                    3'd0:    begin mul_a = 32'(ln_reg[1]); mul_b = 32'(rn_reg[2]); end
                    3'd1:    begin mul_a = 32'(ln_reg[2]); mul_b = 32'(rn_reg[1]); end
                    3'd2:    begin mul_a = 32'(ln_reg[2]); mul_b = 32'(rn_reg[0]); end
                    3'd3:    begin mul_a = 32'(ln_reg[0]); mul_b = 32'(rn_reg[2]); end
                    3'd4:    begin mul_a = 32'(ln_reg[0]); mul_b = 32'(rn_reg[1]); end
                    default: begin mul_a = 32'(ln_reg[1]); mul_b = 32'(rn_reg[0]); end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounding half away from zero and saturation of the scaled coordinate
    always_comb
    begin
        smag = prod_reg[40] ? 41'(-prod_reg[40:0]) : prod_reg[40:0];
        sq   = 33'((42'(smag) + 42'd128) >> 8);
        if (!prod_reg[40])
            srnd = (sq > 33'(POS_MAX)) ? POS_MAX : sq[23:0];
        else
            srnd = (sq > 33'd8388608) ? POS_MIN : 24'(-sq);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dmag[i] = abs32(d_reg[i]);
            nq[i]   = nrm_q_reg[(2-i)*NRM_W +: NRM_W];
            nsum[i] = 17'(nq[i]) + 17'(fn_reg[i]);
        end
        nz = (nrm_q_reg == '0);
        for (int i = 0; i < 3; i++)
            mc[i] = nz ? fn_reg[i] : nsum[i][NRM_W:1];
    end

    always_comb
    begin
        isum = 64'(ir_reg) + 64'(ibit_reg);
        ige  = 64'(iv_reg) >= isum;
        dnum = {dsel[31] ? 31'(-dsel) : dsel[30:0], 14'd0} + 45'(len >> 1);
        dtry = {drem_reg, dlo_reg[15]};
        dge  = dtry >= {1'b0, len};
    end

    always_comb
    begin
        stat.kind       = item_reg.kind;
        stat.full       = (count_reg == CNT_W'(MAX_VERTICES));
        stat.corner_bad = (item_reg.corner_a == '0) || (item_reg.corner_b == '0) ||
                          (item_reg.corner_c == '0) ||
                          (CNT_W'(item_reg.corner_a) > count_reg) ||
                          (CNT_W'(item_reg.corner_b) > count_reg) ||
                          (CNT_W'(item_reg.corner_c) > count_reg);
        stat.read_bad   = (CNT_W'(item_reg.read_index) >= count_reg);
        stat.mx_zero    = (dmag[0] == '0) && (dmag[1] == '0) && (dmag[2] == '0);
        stat.mx_big     = (dmag[0][30:29] != 2'b00) || (dmag[1][30:29] != 2'b00) ||
                          (dmag[2][30:29] != 2'b00);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scale_reg     <= 16'd256;
            out_valid_reg <= 1'b0;
            mop_reg       <= MP_NONE;
            rdp_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                scale_reg <= cfg_data;
            if (cmd.op == OP_WR_VTX)
                count_reg <= count_reg + 1'b1;
            else if (cmd.op == OP_CLEAR)
                count_reg <= '0;
            if (res_op)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_SCALE: mop_reg <= MP_SCALE;
                OP_SQ:    mop_reg <= MP_SQ;
                OP_CROSS: mop_reg <= cmd.sel[0] ? MP_XSUB : MP_XSET;
                default:  mop_reg <= MP_NONE;
            endcase
            rdp_pend_reg <= (cmd.op == OP_RD_POS);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_a * mul_b;
        msel_reg    <= cmd.sel;
        rdp_sel_reg <= cmd.sel[1:0];

        if (rdp_pend_reg)
            pp_reg[rdp_sel_reg] <= pos_q_reg;

        case (mop_reg)
            MP_SCALE: pnew_reg[msel_reg[1:0]] <= srnd;
            MP_SQ:    ssum_reg <= ssum_reg + prod_reg[61:0];
            MP_XSET:  d_reg[msel_reg[2:1]] <= prod_reg[31:0];
            default:  ;
        endcase
        // odd cross terms subtract from the component set by the even term just before them
        if (mop_reg == MP_XSUB)
        begin
            case (msel_reg)
                3'd1:    d_reg[0] <= d_reg[0] - prod_reg[31:0];
                3'd3:    d_reg[1] <= d_reg[1] - prod_reg[31:0];
                default: d_reg[2] <= d_reg[2] - prod_reg[31:0];
            endcase
        end

        case (cmd.op)
            OP_LATCH:
            begin
                item_reg  <= in_data;
                vi_reg[0] <= (in_data.kind == KIND_READ) ? in_data.read_index
                                                          : IDX_W'(in_data.corner_a - 1'b1);
                vi_reg[1] <= IDX_W'(in_data.corner_c - 1'b1);
                vi_reg[2] <= IDX_W'(in_data.corner_b - 1'b1);
            end
            OP_LOAD_L:
                for (int i = 0; i < 3; i++)
                    d_reg[i] <= 32'(pcomp(pp_reg[1], i)) - 32'(pcomp(pp_reg[0], i));
            OP_LOAD_R:
                for (int i = 0; i < 3; i++)
                    d_reg[i] <= 32'(pcomp(pp_reg[1], i)) - 32'(pcomp(pp_reg[2], i));
            OP_SHIFT:
                for (int i = 0; i < 3; i++)
                    d_reg[i] <= d_reg[i] <<< 1;
            OP_NRM_ZERO:
                for (int i = 0; i < 3; i++)
                    nres_reg[i] <= '0;
            OP_SQ:
                if (cmd.sel[1:0] == 2'd0)
                    ssum_reg <= '0;
            OP_ISQ_INIT:
            begin
                iv_reg   <= ssum_reg;
                ir_reg   <= '0;
                ibit_reg <= 63'd1 << 62;
            end
            OP_ISQ_STEP:
            begin
                if (ige)
                begin
                    iv_reg <= 62'(64'(iv_reg) - isum);
                    ir_reg <= (ir_reg >> 1) + ibit_reg;
                end
                else
                begin
                    ir_reg <= ir_reg >> 1;
                end
                ibit_reg <= ibit_reg >> 2;
            end
            OP_DIV_INIT:
            begin
                drem_reg <= 31'(dnum[44:16]);
                dlo_reg  <= dnum[15:0];
                dq_reg   <= '0;
                dneg_reg <= dsel[31];
            end
            OP_DIV_STEP:
            begin
                drem_reg <= dge ? 31'(dtry - {1'b0, len}) : dtry[30:0];
                dlo_reg  <= dlo_reg << 1;
                dq_reg   <= {dq_reg[14:0], dge};
            end
            OP_DIV_END:
                nres_reg[cmd.sel[1:0]] <= dneg_reg ? 16'(-dq_reg) : dq_reg;
            OP_NRM_STORE:
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.sel[1:0] == 2'd0)
                        ln_reg[i] <= nres_reg[i];
                    else if (cmd.sel[1:0] == 2'd1)
                        rn_reg[i] <= nres_reg[i];
                    else
                        fn_reg[i] <= nres_reg[i];
                end
            OP_RES_ZERO:
                out_reg <= '{pos_x: '0, pos_y: '0, pos_z: '0,
                             norm_x: '0, norm_y: '0, norm_z: '0,
                             status: cmd.sel[1:0]};
            OP_RES_ADD:
                out_reg <= '{pos_x: pnew_reg[0], pos_y: pnew_reg[1], pos_z: pnew_reg[2],
                             norm_x: '0, norm_y: '0, norm_z: '0,
                             status: STAT_OK};
            OP_RES_TRI:
                out_reg <= '{pos_x: '0, pos_y: '0, pos_z: '0,
                             norm_x: fn_reg[0], norm_y: fn_reg[1], norm_z: fn_reg[2],
                             status: STAT_OK};
            OP_RES_READ:
            begin
                out_reg.pos_x  <= pcomp(pos_q_reg, 0);
                out_reg.pos_y  <= pcomp(pos_q_reg, 1);
                out_reg.pos_z  <= pcomp(pos_q_reg, 2);
                out_reg.norm_x <= nq[0];
                out_reg.norm_y <= nq[1];
                out_reg.norm_z <= nq[2];
                out_reg.status <= STAT_OK;
            end
            default: ;
        endcase
    end

    // vertex position store
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WR_VTX)
            pos_mem[count_reg[IDX_W-1:0]] <= {pnew_reg[0], pnew_reg[1], pnew_reg[2]};
        if ((cmd.op == OP_RD_POS) || (cmd.op == OP_RD_VTX))
            pos_q_reg <= pos_mem[vsel];
    end

    // normal store, a new vertex always starts from a zero normal
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WR_VTX)
            nrm_mem[count_reg[IDX_W-1:0]] <= '0;
        else if (cmd.op == OP_WR_NRM)
            nrm_mem[vsel] <= {mc[0], mc[1], mc[2]};
        if ((cmd.op == OP_RD_NRM) || (cmd.op == OP_RD_VTX))
            nrm_q_reg <= nrm_mem[vsel];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_op |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WR_VTX) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("vertex append did not advance count");

    a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_WR_VTX) |-> !stat.full)
        else $error("append issued into a full store");

endmodule

`default_nettype wire

// ===== sv/mvna_ctrl.sv =====
// controller state machine sequencing the datapath for each item kind
`default_nettype none

module mvna_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output mvna_pkg::dp_cmd_t  cmd,
    input  mvna_pkg::dp_stat_t stat
);
    import mvna_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_SCALE = 5'd2;
    localparam logic [4:0] S_SCW   = 5'd3;
    localparam logic [4:0] S_WRV   = 5'd4;
    localparam logic [4:0] S_RDP   = 5'd5;
    localparam logic [4:0] S_RDW   = 5'd6;
    localparam logic [4:0] S_LOAD  = 5'd7;
    localparam logic [4:0] S_NSH   = 5'd8;
    localparam logic [4:0] S_SQ    = 5'd9;
    localparam logic [4:0] S_SQW   = 5'd10;
    localparam logic [4:0] S_ISI   = 5'd11;
    localparam logic [4:0] S_ISQ   = 5'd12;
    localparam logic [4:0] S_DVI   = 5'd13;
    localparam logic [4:0] S_DVS   = 5'd14;
    localparam logic [4:0] S_DVE   = 5'd15;
    localparam logic [4:0] S_NST   = 5'd16;
    localparam logic [4:0] S_CRS   = 5'd17;
    localparam logic [4:0] S_CRW   = 5'd18;
    localparam logic [4:0] S_RDN   = 5'd19;
    localparam logic [4:0] S_WRN   = 5'd20;
    localparam logic [4:0] S_RDV   = 5'd21;
    localparam logic [4:0] S_RES   = 5'd22;

    localparam logic [4:0] ISQ_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST = 5'd15;

    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_RIGHT = 2'd1;
    localparam logic [1:0] PH_FACE  = 2'd2;

    logic [4:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic [1:0] phase_reg, phase_next;
    dp_cmd_t    res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        phase_next = phase_reg;
        res_next   = res_reg;
        cmd        = '{op: OP_NOP, sel: 3'd0};
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cnt_next = '0;
                unique case (stat.kind)
                    KIND_ADD:
                        if (stat.full)
                        begin
                            res_next   = '{op: OP_RES_ZERO, sel: {1'b0, STAT_FULL}};
                            state_next = S_RES;
                        end
                        else
                        begin
                            state_next = S_SCALE;
                        end
                    KIND_TRI:
                        if (stat.corner_bad)
                        begin
                            res_next   = '{op: OP_RES_ZERO, sel: {1'b0, STAT_BAD_INDEX}};
                            state_next = S_RES;
                        end
                        else
                        begin
                            state_next = S_RDP;
                        end
                    KIND_READ:
                        if (stat.read_bad)
                        begin
                            res_next   = '{op: OP_RES_ZERO, sel: {1'b0, STAT_BAD_INDEX}};
                            state_next = S_RES;
                        end
                        else
                        begin
                            state_next = S_RDV;
                        end
                    default:
                    begin
                        cmd.op     = OP_CLEAR;
                        res_next   = '{op: OP_RES_ZERO, sel: {1'b0, STAT_OK}};
                        state_next = S_RES;
                    end
                endcase
            end
            S_SCALE:
            begin
                cmd = '{op: OP_SCALE, sel: cnt_reg[2:0]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd2)
                    state_next = S_SCW;
            end
            S_SCW:
                state_next = S_WRV;
            S_WRV:
            begin
                cmd.op     = OP_WR_VTX;
                res_next   = '{op: OP_RES_ADD, sel: 3'd0};
                state_next = S_RES;
            end
            S_RDP:
            begin
                cmd = '{op: OP_RD_POS, sel: cnt_reg[2:0]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd2)
                    state_next = S_RDW;
            end
            S_RDW:
            begin
                phase_next = PH_LEFT;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.op     = (phase_reg == PH_LEFT) ? OP_LOAD_L : OP_LOAD_R;
                state_next = S_NSH;
            end
            // scale the vector up until its largest component reaches bit 29; a zero vector gives a zero normal
            S_NSH:
            begin
                cnt_next = '0;
                if (stat.mx_zero)
                begin
                    cmd.op     = OP_NRM_ZERO;
                    state_next = S_NST;
                end
                else if (stat.mx_big)
                begin
                    state_next = S_SQ;
                end
                else
                begin
                    cmd.op = OP_SHIFT;
                end
            end
            S_SQ:
            begin
                cmd = '{op: OP_SQ, sel: cnt_reg[2:0]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd2)
                    state_next = S_SQW;
            end
            S_SQW:
                state_next = S_ISI;
            S_ISI:
            begin
                cmd.op     = OP_ISQ_INIT;
                cnt_next   = '0;
                state_next = S_ISQ;
            end
            S_ISQ:
            begin
                cmd.op   = OP_ISQ_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ISQ_LAST)
                begin
                    comp_next  = '0;
                    state_next = S_DVI;
                end
            end
            S_DVI:
            begin
                cmd = '{op: OP_DIV_INIT, sel: {1'b0, comp_reg}};
                cnt_next   = '0;
                state_next = S_DVS;
            end
            S_DVS:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_DVE;
            end
            S_DVE:
            begin
                cmd = '{op: OP_DIV_END, sel: {1'b0, comp_reg}};
                comp_next = comp_reg + 1'b1;
                state_next = (comp_reg == 2'd2) ? S_NST : S_DVI;
            end
            S_NST:
            begin
                cmd = '{op: OP_NRM_STORE, sel: {1'b0, phase_reg}};
                cnt_next  = '0;
                comp_next = '0;
                unique case (phase_reg)
                    PH_LEFT:
                    begin
                        phase_next = PH_RIGHT;
                        state_next = S_LOAD;
                    end
                    PH_RIGHT:
                    begin
                        phase_next = PH_FACE;
                        state_next = S_CRS;
                    end
                    default:
                        state_next = S_RDN;
                endcase
            end
            S_CRS:
            begin
                cmd = '{op: OP_CROSS, sel: cnt_reg[2:0]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd5)
                    state_next = S_CRW;
            end
            S_CRW:
                state_next = S_NSH;
            // read-modify-write of a, c, b normals in turn
            S_RDN:
            begin
                cmd = '{op: OP_RD_NRM, sel: {1'b0, comp_reg}};
                state_next = S_WRN;
            end
            S_WRN:
            begin
                cmd = '{op: OP_WR_NRM, sel: {1'b0, comp_reg}};
                comp_next = comp_reg + 1'b1;
                if (comp_reg == 2'd2)
                begin
                    res_next   = '{op: OP_RES_TRI, sel: 3'd0};
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_RDN;
                end
            end
            S_RDV:
            begin
                cmd = '{op: OP_RD_VTX, sel: 3'd0};
                res_next   = '{op: OP_RES_READ, sel: 3'd0};
                state_next = S_RES;
            end
            S_RES:
                if (stat.out_free)
                begin
                    cmd        = res_reg;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            phase_reg <= PH_LEFT;
            res_reg   <= '{op: OP_NOP, sel: 3'd0};
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            phase_reg <= phase_next;
            res_reg   <= res_next;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DEC))
        else $error("accepted beat not decoded");

    a_res_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RES && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("result state did not retire");

    a_norm_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRS) |-> (phase_reg == PH_FACE))
        else $error("cross product outside face phase");

endmodule

`default_nettype wire

// ===== bench/mesh_vertex_normal_accumulator_tb.sv =====
// testbench of the mesh vertex normal accumulator: directed and random beats checked against a predictor
`default_nettype none

module mesh_vertex_normal_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvna_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    mesh_vertex_normal_accumulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // predictor state
    logic signed [23:0] mesh_pos [MAX_VERTICES][3];
    logic signed [15:0] mesh_nrm [MAX_VERTICES][3];
    int unsigned        mesh_count;
    logic [15:0]        scale_q8;

    in_item_t  pending_beats [$];
    out_item_t expected_results [$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        error_count;
    int        idle_cycles;
    int unsigned beats_sent;

    function automatic logic signed [23:0] scaled_coord(longint c);
        longint p;
        longint m;
        longint q;
        p = c * longint'(scale_q8);
        m = (p < 0) ? -p : p;
        q = (m + 128) >>> 8;
        if (p < 0)
            q = -q;
        if (q > 8388607)
            q = 8388607;
        if (q < -8388608)
            q = -8388608;
        return q[23:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic unit_vector(input longint v[3], output logic signed [15:0] u[3]);
        longint d[3];
        longint mx;
        longint unsigned s;
        longint unsigned len;
        longint unsigned m;
        longint q;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = v[i];
            if ((d[i] < 0 ? -d[i] : d[i]) > mx)
                mx = d[i] < 0 ? -d[i] : d[i];
        end
        if (mx == 0)
        begin
            for (int i = 0; i < 3; i++)
                u[i] = '0;
            return;
        end
        while (mx < (64'sd1 << 29))
        begin
            mx = mx * 2;
            for (int i = 0; i < 3; i++)
                d[i] = d[i] * 2;
        end
        s = 0;
        for (int i = 0; i < 3; i++)
            s = s + longint'(d[i] * d[i]);
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            m = (d[i] < 0 ? -d[i] : d[i]) * 16384;
            q = (m + len / 2) / len;
            u[i] = (d[i] < 0) ? 16'(-q) : 16'(q);
        end
    endtask

    task automatic merge_into(input int unsigned vi, input logic signed [15:0] f[3]);
        longint s;
        if (mesh_nrm[vi][0] == 0 && mesh_nrm[vi][1] == 0 && mesh_nrm[vi][2] == 0)
        begin
            for (int i = 0; i < 3; i++)
                mesh_nrm[vi][i] = f[i];
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            s = longint'(mesh_nrm[vi][i]) + longint'(f[i]);
            mesh_nrm[vi][i] = 16'(s >>> 1);
        end
    endtask

    task automatic predict_item(input in_item_t it);
        out_item_t r;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        longint l[3];
        longint rv[3];
        longint x[3];
        logic signed [15:0] ln[3];
        logic signed [15:0] rn[3];
        logic signed [15:0] fn[3];
        r = '0;
        r.status = STAT_OK;
        case (it.kind)
            KIND_ADD:
            begin
                if (mesh_count >= MAX_VERTICES)
                    r.status = STAT_FULL;
                else
                begin
                    mesh_pos[mesh_count][0] = scaled_coord(longint'(it.coord_x));
                    mesh_pos[mesh_count][1] = scaled_coord(longint'(it.coord_y));
                    mesh_pos[mesh_count][2] = scaled_coord(-longint'(it.coord_z));
                    for (int i = 0; i < 3; i++)
                        mesh_nrm[mesh_count][i] = '0;
                    r.pos_x = mesh_pos[mesh_count][0];
                    r.pos_y = mesh_pos[mesh_count][1];
                    r.pos_z = mesh_pos[mesh_count][2];
                    mesh_count++;
                end
            end
            KIND_TRI:
            begin
                a = it.corner_a;
                b = it.corner_b;
                c = it.corner_c;
                if (a == 0 || b == 0 || c == 0 || a > mesh_count || b > mesh_count
                    || c > mesh_count)
                    r.status = STAT_BAD_INDEX;
                else
                begin
                    // corners taken as a, c, b
                    for (int i = 0; i < 3; i++)
                    begin
                        l[i] = longint'(mesh_pos[c-1][i]) - longint'(mesh_pos[a-1][i]);
                        rv[i] = longint'(mesh_pos[c-1][i]) - longint'(mesh_pos[b-1][i]);
                    end
                    unit_vector(l, ln);
                    unit_vector(rv, rn);
                    x[0] = longint'(ln[1]) * rn[2] - longint'(ln[2]) * rn[1];
                    x[1] = longint'(ln[2]) * rn[0] - longint'(ln[0]) * rn[2];
                    x[2] = longint'(ln[0]) * rn[1] - longint'(ln[1]) * rn[0];
                    unit_vector(x, fn);
                    merge_into(a - 1, fn);
                    merge_into(c - 1, fn);
                    merge_into(b - 1, fn);
                    r.norm_x = fn[0];
                    r.norm_y = fn[1];
                    r.norm_z = fn[2];
                end
            end
            KIND_READ:
            begin
                if (it.read_index >= mesh_count)
                    r.status = STAT_BAD_INDEX;
                else
                begin
                    r.pos_x  = mesh_pos[it.read_index][0];
                    r.pos_y  = mesh_pos[it.read_index][1];
                    r.pos_z  = mesh_pos[it.read_index][2];
                    r.norm_x = mesh_nrm[it.read_index][0];
                    r.norm_y = mesh_nrm[it.read_index][1];
                    r.norm_z = mesh_nrm[it.read_index][2];
                end
            end
            default:
            begin
                mesh_count = 0;
                for (int v = 0; v < MAX_VERTICES; v++)
                    for (int i = 0; i < 3; i++)
                        mesh_nrm[v][i] = '0;
            end
        endcase
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic queue_beat(input in_item_t it);
        pending_beats.insert(pending_beats.size(), it);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                predict_item(in_data);
                beats_sent++;
            end
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_beats.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    error_count++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (out_data.pos_x !== e.pos_x)
                        $error("pos_x expected %0d got %0d", e.pos_x, out_data.pos_x);
                    if (out_data.pos_y !== e.pos_y)
                        $error("pos_y expected %0d got %0d", e.pos_y, out_data.pos_y);
                    if (out_data.pos_z !== e.pos_z)
                        $error("pos_z expected %0d got %0d", e.pos_z, out_data.pos_z);
                    if (out_data.norm_x !== e.norm_x)
                        $error("norm_x expected %0d got %0d", e.norm_x, out_data.norm_x);
                    if (out_data.norm_y !== e.norm_y)
                        $error("norm_y expected %0d got %0d", e.norm_y, out_data.norm_y);
                    if (out_data.norm_z !== e.norm_z)
                        $error("norm_z expected %0d got %0d", e.norm_z, out_data.norm_z);
                    if (out_data.status !== e.status)
                        $error("status expected %0d got %0d", e.status, out_data.status);
                    if (out_data !== e)
                        error_count++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic in_item_t rand_beat(logic [1:0] k);
        in_item_t it;
        it.kind       = k;
        it.coord_x    = 24'($urandom);
        it.coord_y    = 24'($urandom);
        it.coord_z    = 24'($urandom);
        it.corner_a   = 11'($urandom_range(2047));
        it.corner_b   = 11'($urandom_range(2047));
        it.corner_c   = 11'($urandom_range(2047));
        it.read_index = 10'($urandom);
        return it;
    endfunction

    // mostly valid corners, sometimes bad or degenerate
    function automatic logic [10:0] pick_corner(int unsigned cnt);
        int unsigned p;
        p = $urandom_range(99);
        if (cnt == 0 || p < 5)
            return 11'($urandom_range(2047));
        if (p < 8)
            return 11'(cnt + 1);
        if (p < 10)
            return '0;
        return 11'($urandom_range(cnt, 1));
    endfunction

    function automatic in_item_t vertex_beat();
        in_item_t it;
        int unsigned p;
        it = rand_beat(KIND_ADD);
        p = $urandom_range(3);
        // small coordinates keep differences well spread
        if (p != 0)
        begin
            it.coord_x = 24'(int'($urandom_range(40000)) - 20000);
            it.coord_y = 24'(int'($urandom_range(40000)) - 20000);
            it.coord_z = 24'(int'($urandom_range(40000)) - 20000);
        end
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_scale(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        scale_q8 = v;
    endtask

    task automatic random_mesh(input int n_items);
        int unsigned cnt;
        int unsigned p;
        in_item_t it;
        cnt = mesh_count;
        for (int n = 0; n < n_items; n++)
        begin
            p = $urandom_range(99);
            if (cnt < 3 || p < 30)
            begin
                it = vertex_beat();
                if (cnt < MAX_VERTICES)
                    cnt++;
            end
            else if (p < 70)
            begin
                it = rand_beat(KIND_TRI);
                it.corner_a = pick_corner(cnt);
                it.corner_b = pick_corner(cnt);
                it.corner_c = pick_corner(cnt);
            end
            else if (p < 97)
            begin
                it = rand_beat(KIND_READ);
                if ($urandom_range(9) != 0)
                    it.read_index = 10'($urandom_range(cnt - 1));
            end
            else
            begin
                it = rand_beat(KIND_NEW);
                cnt = 0;
            end
            queue_beat(it);
        end
    endtask

    initial
    begin
        in_item_t it;
        logic [15:0] scales[5];
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mesh_count     = 0;
        scale_q8       = 16'd256;
        for (int v = 0; v < MAX_VERTICES; v++)
            for (int i = 0; i < 3; i++)
            begin
                mesh_pos[v][i] = '0;
                mesh_nrm[v][i] = '0;
            end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset scale, extremes, every kind, bad corners, degenerate face
        it = rand_beat(KIND_READ);
        it.read_index = '0;
        queue_beat(it);
        it = rand_beat(KIND_TRI);
        it.corner_a = 11'd1; it.corner_b = 11'd1; it.corner_c = 11'd1;
        queue_beat(it);
        it = rand_beat(KIND_ADD);
        it.coord_x = 24'sh7FFFFF; it.coord_y = 24'sh800000; it.coord_z = 24'sh800000;
        queue_beat(it);
        it.coord_x = '0; it.coord_y = '0; it.coord_z = '0;
        queue_beat(it);
        it.coord_x = 24'sd4096; it.coord_y = 24'sd0; it.coord_z = 24'sd0;
        queue_beat(it);
        it.coord_x = 24'sd0; it.coord_y = 24'sd4096; it.coord_z = 24'sh7FFFFF;
        queue_beat(it);
        it = rand_beat(KIND_TRI);
        it.corner_a = 11'd2; it.corner_b = 11'd3; it.corner_c = 11'd4;
        queue_beat(it);
        it.corner_a = 11'd2; it.corner_b = 11'd2; it.corner_c = 11'd3;
        queue_beat(it);
        it.corner_a = 11'd1; it.corner_b = 11'd3; it.corner_c = 11'd4;
        queue_beat(it);
        it.corner_a = 11'd0; it.corner_b = 11'd1; it.corner_c = 11'd2;
        queue_beat(it);
        it.corner_a = 11'd1; it.corner_b = 11'd5; it.corner_c = 11'd2;
        queue_beat(it);
        it.corner_a = 11'd1024; it.corner_b = 11'd2047; it.corner_c = 11'd2;
        queue_beat(it);
        for (int i = 0; i < 5; i++)
        begin
            it = rand_beat(KIND_READ);
            it.read_index = 10'(i == 4 ? 1023 : i);
            queue_beat(it);
        end
        queue_beat(rand_beat(KIND_NEW));
        it = rand_beat(KIND_READ);
        it.read_index = '0;
        queue_beat(it);
        wait_drained();

        // fill the vertex store to its limit, then overflow
        write_scale(16'd128);
        for (int i = 0; i < MAX_VERTICES + 2; i++)
            queue_beat(vertex_beat());
        it = rand_beat(KIND_TRI);
        it.corner_a = 11'd1024; it.corner_b = 11'd1; it.corner_c = 11'd512;
        queue_beat(it);
        it = rand_beat(KIND_READ);
        it.read_index = 10'd1023;
        queue_beat(it);
        it.corner_a = 11'd1025;
        queue_beat(rand_beat(KIND_NEW));
        wait_drained();

        scales[0] = 16'd0;
        scales[1] = 16'hFFFF;
        scales[2] = 16'd256;
        scales[3] = 16'(16'd1 + $urandom_range(65534));
        scales[4] = 16'd1;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_scale(scales[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            random_mesh(40);
            wait_drained();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/mvna_pkg.sv
sv/mvna_dp.sv
sv/mvna_ctrl.sv
sv/mesh_vertex_normal_accumulator.sv
bench/mesh_vertex_normal_accumulator_tb.sv
